// ===== sv/pfcb_pkg.sv =====
// ----------------------------------------------------------------------------
// pfcb_pkg
// shared types and constants of the palette fade color blender
// ----------------------------------------------------------------------------
`default_nettype none

package pfcb_pkg;

    // channel and level widths
    localparam int unsigned CHAN_W  = 5;
    localparam int unsigned LEVEL_W = 5;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 5'd16;
    localparam logic [CHAN_W-1:0]  CHAN_MAX   = 5'd31;

    // step divider widths: quotient of (4096 + d - 1) / d
    localparam int unsigned DIV_NUM_W = 13;
    localparam int unsigned DIV_DEN_W = 8;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W + 1);
    localparam logic [DIV_NUM_W-1:0] STEP_SCALE_M1 = 13'd4095;

    // request codes
    typedef enum logic [2:0] {
        REQ_COLOR    = 3'd0,
        REQ_TICK     = 3'd1,
        REQ_FADE_OUT = 3'd2,
        REQ_FADE_IN  = 3'd3,
        REQ_STOP     = 3'd4
    } req_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ===== sv/palette_fade_color_blender.sv =====
// ----------------------------------------------------------------------------
// palette_fade_color_blender
// fade engine for split-component palette words, black or white target
// ----------------------------------------------------------------------------
// sequence: a color request at nonzero level blends its three channels one at a
//   time, then pushes; tick, stop and color at level 0 go straight to ST_PUSH
// fade start: waits in ST_DIV for the 13-step divider, then pushes
// one request in flight; a finished result waits in the output register
// reset: level 0, target white, no fade, progress and step cleared
`default_nettype none

module palette_fade_color_blender
    import pfcb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  req_type,
    input  wire logic [15:0] color_in,
    input  wire logic        fade_target,
    input  wire logic [7:0]  fade_frames,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      color_out,
    output logic [4:0]       cur_level,
    output logic             is_fading,
    output logic             level_changed
);

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BLEND,
        ST_DIV,
        ST_PUSH
    } state_t;

    // fade modes
    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_OUT  = 2'd1,
        MODE_IN   = 2'd2
    } mode_t;

    state_t                state_reg,  state_next;
    logic [1:0]            ch_reg,     ch_next;
    logic [LEVEL_W-1:0]    level_reg,  level_next;
    logic                  white_reg,  white_next;
    mode_t                 mode_reg,   mode_next;
    logic [7:0]            frames_reg, frames_next;
    logic [15:0]           acc_reg,    acc_next;
    logic [DIV_NUM_W-1:0]  step_reg,   step_next;
    logic [15:0]           src_reg,    src_next;
    logic [15:0]           res_color_reg, res_color_next;
    logic                  res_chg_reg,   res_chg_next;

    logic                  out_valid_reg,  out_valid_next;
    logic [15:0]           color_out_reg,  color_out_next;
    logic [LEVEL_W-1:0]    cur_level_reg,  cur_level_next;
    logic                  is_fading_reg,  is_fading_next;
    logic                  level_chg_reg,  level_chg_next;

    logic                  accept;
    logic                  push_ok;

    // tick arithmetic
    logic [7:0]            frames_dec;
    logic [15:0]           acc_sum;
    logic [LEVEL_W-1:0]    part;
    logic [LEVEL_W-1:0]    tick_level;

    // divider hookup
    logic                  div_start;
    logic [DIV_NUM_W-1:0]  div_numer;
    logic [DIV_DEN_W-1:0]  dur;
    div_stat_t             div_stat;
    logic [DIV_NUM_W-1:0]  div_quot;

    // shared channel blender
    logic [CHAN_W-1:0]     blend_in;
    logic [CHAN_W-1:0]     blend_out;

    assign accept  = in_valid && (state_reg == ST_IDLE);
    assign push_ok = !out_valid_reg || !out_stall;

    // duration zero counts as one frame; step = ceil(4096 / d)
    assign dur       = (fade_frames == 8'd0) ? 8'd1 : fade_frames;
    assign div_numer = STEP_SCALE_M1 + DIV_NUM_W'(dur);
    assign div_start = accept
                    && ((req_type == REQ_FADE_OUT) || (req_type == REQ_FADE_IN));

    pfcb_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (dur),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    // tick: on the last frame the part is full, else progress >> 8 clamped
    assign frames_dec = frames_reg - 8'd1;
    assign acc_sum    = acc_reg + {3'b000, step_reg};
    always_comb
    begin
        if (frames_dec == 8'd0)
        begin
            part = FULL_LEVEL;
        end
        else if (acc_sum[15:8] > 8'(FULL_LEVEL))
        begin
            part = FULL_LEVEL;
        end
        else
        begin
            part = acc_sum[12:8];
        end
    end
    assign tick_level = (mode_reg == MODE_OUT) ? part : (FULL_LEVEL - part);

    // channel select: red, green, blue, low bit at 14, 13, 12
    always_comb
    begin
        unique case (ch_reg)
            2'd0:    blend_in = {src_reg[11:8], src_reg[14]};
            2'd1:    blend_in = {src_reg[7:4],  src_reg[13]};
            2'd2:    blend_in = {src_reg[3:0],  src_reg[12]};
            default: blend_in = '0;
        endcase
    end

    pfcb_blend u_blend
    (
        .chan_in  (blend_in),
        .level    (level_reg),
        .white    (white_reg),
        .chan_out (blend_out)
    );

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        level_next     = level_reg;
        white_next     = white_reg;
        mode_next      = mode_reg;
        frames_next    = frames_reg;
        acc_next       = acc_reg;
        step_next      = step_reg;
        src_next       = src_reg;
        res_color_next = res_color_reg;
        res_chg_next   = res_chg_reg;

        out_valid_next = out_valid_reg;
        color_out_next = color_out_reg;
        cur_level_next = cur_level_reg;
        is_fading_next = is_fading_reg;
        level_chg_next = level_chg_reg;

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_color_next = '0;
                    res_chg_next   = 1'b0;
                    state_next     = ST_PUSH;
                    unique case (req_type)
                        REQ_COLOR:
                        begin
                            if (level_reg == '0)
                            begin
                                res_color_next = color_in;
                            end
                            else
                            begin
                                // dark bit stays cleared
                                src_next   = color_in;
                                ch_next    = 2'd0;
                                state_next = ST_BLEND;
                            end
                        end
                        REQ_TICK:
                        begin
                            if (mode_reg != MODE_NONE)
                            begin
                                frames_next  = frames_dec;
                                if (frames_dec != 8'd0)
                                begin
                                    acc_next = acc_sum;
                                end
                                else
                                begin
                                    mode_next = MODE_NONE;
                                end
                                level_next   = tick_level;
                                res_chg_next = (tick_level != level_reg);
                            end
                        end
                        REQ_FADE_OUT:
                        begin
                            mode_next   = MODE_OUT;
                            frames_next = dur;
                            acc_next    = '0;
                            if (fade_target != white_reg)
                            begin
                                white_next   = fade_target;
                                res_chg_next = (level_reg != '0);
                            end
                            state_next  = ST_DIV;
                        end
                        REQ_FADE_IN:
                        begin
                            mode_next    = MODE_IN;
                            frames_next  = dur;
                            acc_next     = '0;
                            white_next   = fade_target;
                            level_next   = FULL_LEVEL;
                            res_chg_next = 1'b1;
                            state_next   = ST_DIV;
                        end
                        REQ_STOP:
                        begin
                            mode_next    = MODE_NONE;
                            level_next   = '0;
                            res_chg_next = (level_reg != '0);
                        end
                        default:
                        begin
                            // unknown request: no effect
                        end
                    endcase
                end
            end
            ST_BLEND:
            begin
                // one channel per cycle through the shared blender
                unique case (ch_reg)
                    2'd0:
                    begin
                        res_color_next[14]   = blend_out[0];
                        res_color_next[11:8] = blend_out[4:1];
                    end
                    2'd1:
                    begin
                        res_color_next[13]  = blend_out[0];
                        res_color_next[7:4] = blend_out[4:1];
                    end
                    default:
                    begin
                        res_color_next[12]  = blend_out[0];
                        res_color_next[3:0] = blend_out[4:1];
                    end
                endcase
                ch_next = ch_reg + 2'd1;
                if (ch_reg == 2'd2)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    step_next  = div_quot;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                // level and mode are already final for this request
                if (push_ok)
                begin
                    out_valid_next = 1'b1;
                    color_out_next = res_color_reg;
                    cur_level_next = level_reg;
                    is_fading_next = (mode_reg != MODE_NONE);
                    level_chg_next = res_chg_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= '0;
            level_reg     <= '0;
            white_reg     <= 1'b1;
            mode_reg      <= MODE_NONE;
            frames_reg    <= '0;
            acc_reg       <= '0;
            step_reg      <= '0;
            src_reg       <= '0;
            res_color_reg <= '0;
            res_chg_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            color_out_reg <= '0;
            cur_level_reg <= '0;
            is_fading_reg <= 1'b0;
            level_chg_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            level_reg     <= level_next;
            white_reg     <= white_next;
            mode_reg      <= mode_next;
            frames_reg    <= frames_next;
            acc_reg       <= acc_next;
            step_reg      <= step_next;
            src_reg       <= src_next;
            res_color_reg <= res_color_next;
            res_chg_reg   <= res_chg_next;
            out_valid_reg <= out_valid_next;
            color_out_reg <= color_out_next;
            cur_level_reg <= cur_level_next;
            is_fading_reg <= is_fading_next;
            level_chg_reg <= level_chg_next;
        end
    end

    // busy until the current request has been handed to the output register
    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign color_out     = color_out_reg;
    assign cur_level     = cur_level_reg;
    assign is_fading     = is_fading_reg;
    assign level_changed = level_chg_reg;

endmodule

`default_nettype wire

// ===== sv/pfcb_blend.sv =====
// ----------------------------------------------------------------------------
// pfcb_blend
// one 5-bit channel moved level/16 of the way toward black or white
// ----------------------------------------------------------------------------
`default_nettype none

module pfcb_blend
    import pfcb_pkg::*;
(
    input  wire logic [CHAN_W-1:0]  chan_in,
    input  wire logic [LEVEL_W-1:0] level,
    input  wire logic               white,
    output logic      [CHAN_W-1:0]  chan_out
);

    localparam int unsigned PROD_W = CHAN_W + LEVEL_W - 1;

    logic [CHAN_W-1:0] mult_a;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] prod_adj;

    // white: distance to max, rounded down; black: value, rounded up
    assign mult_a   = white ? (CHAN_MAX - chan_in) : chan_in;
    assign prod     = PROD_W'(mult_a) * PROD_W'(level);
    assign prod_adj = white ? prod : PROD_W'(prod + PROD_W'(15));

    always_comb
    begin
        if (white)
        begin
            chan_out = chan_in + prod_adj[PROD_W-1:4];
        end
        else
        begin
            chan_out = chan_in - prod_adj[PROD_W-1:4];
        end
    end

endmodule

`default_nettype wire

// ===== sv/pfcb_div.sv =====
// ----------------------------------------------------------------------------
// pfcb_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pfcb_div
    import pfcb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [DIV_NUM_W-1:0] numer,
    input  wire logic [DIV_DEN_W-1:0] denom,
    output div_stat_t                 stat,
    output logic      [DIV_NUM_W-1:0] quot
);

    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    assign trial = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                num_reg  <= numer;
                den_reg  <= denom;
                rem_reg  <= '0;
                cnt_reg  <= DIV_CNT_W'(DIV_NUM_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                num_reg <= {num_reg[DIV_NUM_W-2:0], ge};
                rem_reg <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = num_reg;

endmodule

`default_nettype wire

// ===== bench/palette_fade_color_blender_test.sv =====
// ----------------------------------------------------------------------------
// palette_fade_color_blender_test
// self-checking bench: a shadow fade engine predicts every result, a queue
// of requests feeds a clocked driver, a clocked monitor compares each result
// field by field; random idling on both sides plus one long output hold-off
// ----------------------------------------------------------------------------
`default_nettype none

module palette_fade_color_blender_test;
    import pfcb_pkg::*;

    // fade sequencer modes of the shadow engine
    typedef enum logic [1:0] {
        FADE_IDLE    = 2'd0,
        FADE_OUT_RUN = 2'd1,
        FADE_IN_RUN  = 2'd2
    } fade_mode_t;

    typedef struct packed {
        logic [2:0]  req;
        logic [15:0] color;
        logic        tgt;
        logic [7:0]  frames;
    } fade_req_t;

    typedef struct packed {
        logic [15:0] color;
        logic [4:0]  level;
        logic        fading;
        logic        changed;
    } fade_result_t;

    localparam int          STEP_SCALE  = 4096;
    localparam int          PHASE_ITEMS = 460;
    localparam int unsigned CYCLE_LIMIT = 400000;
    // slowest request is the fade start, leave plenty of margin
    localparam int          TAIL_CYCLES = 40;
    // long output hold-off: when it starts and how long it lasts
    localparam int unsigned CHOKE_AT    = 700;
    localparam int unsigned CHOKE_LEN   = 400;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [2:0]  req_type      = REQ_COLOR;
    logic [15:0] color_in      = 16'h0000;
    logic        fade_target   = 1'b0;
    logic [7:0]  fade_frames   = 8'h00;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic [15:0] color_out;
    logic [4:0]  cur_level;
    logic        is_fading;
    logic        level_changed;

    // requests waiting to be driven, results waiting to be seen
    fade_req_t    req_backlog[$];
    fade_result_t blend_expect_q[$];
    fade_req_t    next_req;
    fade_result_t seen;

    int unsigned queued_total  = 0;
    int unsigned taken         = 0;
    int unsigned mismatches    = 0;
    int unsigned cycles        = 0;
    int unsigned choke_left    = 0;
    logic        choke_used    = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // shadow state of the fade engine
    logic [4:0]  shadow_level;
    logic        shadow_white;
    fade_mode_t  shadow_mode;
    logic [7:0]  shadow_frames;
    logic [15:0] shadow_acc;
    logic [12:0] shadow_step;

    palette_fade_color_blender dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .color_in      (color_in),
        .fade_target   (fade_target),
        .fade_frames   (fade_frames),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .color_out     (color_out),
        .cur_level     (cur_level),
        .is_fading     (is_fading),
        .level_changed (level_changed)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // shadow fade engine
    // ------------------------------------------------------------------

    // one 5-bit channel moved level/16 of the way to the target, floor
    function automatic logic [4:0] shade_chan(input logic [4:0] v);
        logic [9:0] prod;
        if (shadow_white)
        begin
            prod = (CHAN_MAX - v) * shadow_level;
            return v + prod[8:4];
        end
        // toward black: v - ceil(v * level / 16)
        prod = v * shadow_level + 10'd15;
        return v - prod[8:4];
    endfunction

    // unpack the split channels, blend, repack with the dark bit cleared; level 0 passes the word through
    function automatic logic [15:0] shade_word(input logic [15:0] c);
        logic [4:0] r;
        logic [4:0] g;
        logic [4:0] b;
        if (shadow_level == 5'd0)
            return c;
        r = shade_chan({c[11:8], c[14]});
        g = shade_chan({c[7:4], c[13]});
        b = shade_chan({c[3:0], c[12]});
        return {1'b0, r[0], g[0], b[0], r[4:1], g[4:1], b[4:1]};
    endfunction

    // fade start: duration 0 counts as 1, step = ceil(4096 / frames)
    task automatic load_fade(input fade_mode_t mode, input logic [7:0] frames);
        int d;
        int q;
        d = (frames == 8'd0) ? 1 : int'(frames);
        q = (STEP_SCALE + d - 1) / d;
        shadow_mode   = mode;
        shadow_frames = 8'(d);
        shadow_acc    = 16'd0;
        shadow_step   = q[12:0];
    endtask

    // advance the shadow engine by one accepted request, queue its result
    task automatic fade_predict(input fade_req_t r);
        fade_result_t res;
        logic [4:0]   part;
        logic [4:0]   nxt;
        res = '0;
        case (r.req)
            REQ_COLOR:
                res.color = shade_word(r.color);
            REQ_TICK:
                // a tick with no fade running changes nothing
                if (shadow_mode != FADE_IDLE)
                begin
                    shadow_frames = shadow_frames - 8'd1;
                    if (shadow_frames == 8'd0)
                        part = FULL_LEVEL;
                    else
                    begin
                        // 8.8 progress, wraps in 16 bits, part clamped to 16
                        shadow_acc = shadow_acc + 16'(shadow_step);
                        part = (shadow_acc[15:8] > 8'd16) ? FULL_LEVEL
                                                          : shadow_acc[12:8];
                    end
                    nxt = (shadow_mode == FADE_OUT_RUN) ? part : FULL_LEVEL - part;
                    res.changed = (nxt != shadow_level);
                    shadow_level = nxt;
                    if (shadow_frames == 8'd0)
                        shadow_mode = FADE_IDLE;
                end
            REQ_FADE_OUT:
            begin
                load_fade(FADE_OUT_RUN, r.frames);
                // new target only matters to the banks when already faded
                if (r.tgt != shadow_white)
                begin
                    shadow_white = r.tgt;
                    res.changed = (shadow_level != 5'd0);
                end
            end
            REQ_FADE_IN:
            begin
                load_fade(FADE_IN_RUN, r.frames);
                shadow_white = r.tgt;
                shadow_level = FULL_LEVEL;
                res.changed  = 1'b1;
            end
            REQ_STOP:
            begin
                shadow_mode  = FADE_IDLE;
                res.changed  = (shadow_level != 5'd0);
                shadow_level = 5'd0;
            end
            default:
                ; // unknown request codes are ignored but still answered
        endcase
        res.level  = shadow_level;
        res.fading = (shadow_mode != FADE_IDLE);
        blend_expect_q.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------

    task automatic queue_req(input logic [2:0] req, input logic [15:0] color,
                             input logic tgt, input logic [7:0] frames);
        fade_req_t r;
        r.req    = req;
        r.color  = color;
        r.tgt    = tgt;
        r.frames = frames;
        req_backlog.push_back(r);
        queued_total++;
    endtask

    // mostly a complete fade with colors mixed in, sometimes cut short by a
    // stop, sometimes a lone random request (unknown codes included)
    task automatic queue_fade_burst();
        int          kind;
        int          frames;
        int          ticks;
        logic [2:0]  start_req;
        kind = $urandom_range(99);
        if (kind < 12)
        begin
            queue_req(3'($urandom_range(7)), 16'($urandom), 1'($urandom),
                      8'($urandom));
            return;
        end
        frames = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(24);
        start_req = ($urandom_range(1) == 0) ? REQ_FADE_OUT : REQ_FADE_IN;
        queue_req(start_req, 16'($urandom), 1'($urandom), 8'(frames));
        // a couple of ticks past the end exercise the no-fade tick
        ticks = ((frames == 0) ? 1 : frames) + $urandom_range(2);
        for (int i = 0; i < ticks; i++)
        begin
            if ($urandom_range(99) < 3)
            begin
                queue_req(REQ_STOP, 16'($urandom), 1'($urandom), 8'($urandom));
                break;
            end
            if ($urandom_range(99) < 4)
                queue_req(start_req, 16'($urandom), 1'($urandom), 8'($urandom_range(8)));
            queue_req(REQ_TICK, 16'($urandom), 1'($urandom), 8'($urandom));
            repeat ($urandom_range(2))
                queue_req(REQ_COLOR, 16'($urandom), 1'($urandom), 8'($urandom));
        end
    endtask

    // sender pause: nothing offered, nothing in flight, nothing owed
    // sampled on the falling edge so every clocked update has settled
    task automatic wait_drained();
        @(negedge clk);
        while (req_backlog.size() != 0 || in_valid || blend_expect_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_random_phase(input int unsigned send_pct,
                                    input int unsigned recv_pct);
        int unsigned start_cnt;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start_cnt = queued_total;
        while (queued_total - start_cnt < PHASE_ITEMS)
            queue_fade_burst();
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // request driver: presents the backlog, holds a stalled request steady
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                fade_predict('{req: req_type, color: color_in, tgt: fade_target,
                               frames: fade_frames});
                taken <= taken + 1;
            end
            // the slot is free when nothing is shown or it was just taken
            if (!in_valid || !in_stall)
            begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req = req_backlog.pop_front();
                    req_type    <= next_req.req;
                    color_in    <= next_req.color;
                    fade_target <= next_req.tgt;
                    fade_frames <= next_req.frames;
                    in_valid    <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // one long hold-off of the result side while requests keep coming
    always @(posedge clk)
    begin
        if (!choke_used && taken >= CHOKE_AT)
        begin
            choke_used <= 1'b1;
            choke_left <= CHOKE_LEN;
        end
        else if (choke_left != 0)
        begin
            choke_left <= choke_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // result monitor: checks each accepted result against the oldest
    // expectation, then picks the next stall
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (blend_expect_q.size() == 0)
                begin
                    $error("result with no request outstanding: color_out %h level %0d",
                           color_out, cur_level);
                    mismatches++;
                end
                else
                begin
                    seen = blend_expect_q.pop_front();
                    if (color_out !== seen.color)
                    begin
                        $error("color_out expected %h got %h", seen.color, color_out);
                        mismatches++;
                    end
                    if (cur_level !== seen.level)
                    begin
                        $error("cur_level expected %0d got %0d", seen.level, cur_level);
                        mismatches++;
                    end
                    if (is_fading !== seen.fading)
                    begin
                        $error("is_fading expected %b got %b", seen.fading, is_fading);
                        mismatches++;
                    end
                    if (level_changed !== seen.changed)
                    begin
                        $error("level_changed expected %b got %b", seen.changed,
                               level_changed);
                        mismatches++;
                    end
                end
            end
            out_stall <= (choke_left != 0) || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("palette_fade_color_blender_test NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------
    initial
    begin
        shadow_level  = 5'd0;
        shadow_white  = 1'b1;
        shadow_mode   = FADE_IDLE;
        shadow_frames = 8'd0;
        shadow_acc    = 16'd0;
        shadow_step   = 13'd0;
        send_idle_pct = 24;
        recv_idle_pct = 51;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: passthrough at level 0, idle tick and stop
        queue_req(REQ_COLOR, 16'h0000, 1'b0, 8'h00);
        queue_req(REQ_COLOR, 16'hFFFF, 1'b0, 8'h00);
        queue_req(REQ_TICK,  16'hFFFF, 1'b1, 8'hFF);
        queue_req(REQ_STOP,  16'h0000, 1'b0, 8'h00);
        // zero duration fade out toward the same white target
        queue_req(REQ_FADE_OUT, 16'h0000, 1'b1, 8'h00);
        queue_req(REQ_TICK,  16'h0000, 1'b0, 8'h00);
        queue_req(REQ_COLOR, 16'hFFFF, 1'b0, 8'h00);
        queue_req(REQ_COLOR, 16'h0000, 1'b0, 8'h00);
        // fully faded: same target keeps the banks, new target redraws them
        queue_req(REQ_FADE_OUT, 16'h0000, 1'b1, 8'hFF);
        queue_req(REQ_FADE_OUT, 16'h0000, 1'b0, 8'hFF);
        queue_req(REQ_COLOR, 16'h7FFF, 1'b0, 8'h00);
        queue_req(REQ_TICK,  16'h0000, 1'b0, 8'h00);
        queue_req(REQ_COLOR, 16'h8A5C, 1'b0, 8'h00);
        // stop with a fade running at level 0, then a new target at level 0
        queue_req(REQ_STOP,  16'h0000, 1'b0, 8'h00);
        queue_req(REQ_FADE_OUT, 16'h0000, 1'b1, 8'h03);
        queue_req(REQ_TICK,  16'h0000, 1'b0, 8'h00);
        queue_req(REQ_TICK,  16'h0000, 1'b0, 8'h00);
        queue_req(REQ_COLOR, 16'h1234, 1'b0, 8'h00);
        queue_req(REQ_TICK,  16'h0000, 1'b0, 8'h00);
        queue_req(REQ_TICK,  16'h0000, 1'b0, 8'h00);
        // fade in from black jumps to full level first
        queue_req(REQ_FADE_IN, 16'h0000, 1'b0, 8'h02);
        queue_req(REQ_COLOR, 16'hFFFF, 1'b0, 8'h00);
        queue_req(REQ_TICK,  16'h0000, 1'b0, 8'h00);
        queue_req(REQ_TICK,  16'h0000, 1'b0, 8'h00);
        // unknown request codes
        queue_req(3'd5, 16'hFFFF, 1'b1, 8'hFF);
        queue_req(3'd6, 16'hFFFF, 1'b1, 8'hFF);
        queue_req(3'd7, 16'hFFFF, 1'b1, 8'hFF);
        wait_drained();

        // random: sender light / receiver heavy, then swapped, then no idling
        run_random_phase(24, 51);
        run_random_phase(51, 24);
        run_random_phase(0, 0);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && blend_expect_q.size() == 0 && req_backlog.size() == 0
            && taken == queued_total)
            $display("palette_fade_color_blender_test OK");
        else
            $display("palette_fade_color_blender_test NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
